// ===== hw/rtl/aimu_pkg.sv =====
// Package with widths, keyword codes and parser constants for the line mean block.
package aimu_pkg;
    localparam int COUNT_BITS_DEF   = 32;
    localparam int NUM_CHANNELS_DEF = 6;
    localparam int SUM_W            = 48;
    localparam int MAG_W            = 17;
    localparam int VAL_W            = 16;
    localparam int LINES_W          = 32;
    localparam logic [MAG_W-1:0] MAG_MAX = 17'h1FFFF;
    localparam int NUM_KEYS = 7;

    localparam logic [23:0] KEY_CODES [NUM_KEYS] = '{
        24'h416358, 24'h416359, 24'h41635A, 24'h546D70,
        24'h477958, 24'h477959, 24'h47795A
    };
    localparam logic [2:0] TMP_KEY = 3'd3;

    localparam logic [1:0] PH_SKIP  = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    function automatic logic f_is_sep(input logic [7:0] c);
        return c == 8'h20 || c == 8'h3D || c == 8'h7C;
    endfunction

    function automatic logic f_is_ws(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction
endpackage

// ===== hw/rtl/ascii_imu_line_running_mean.sv =====
// Top level: text line parser, running sums and a shared serial divider for the means.
// A byte without line end is taken whenever o_stall is low and raises no stall.
// A line-end byte closes the line, then one shared restoring divider computes the six means
// in turn; the mean word is offered after the S_OUT state, and input stays stalled until then
// and while the offered mean word is held by i_stall.
// Synchronous active-low reset clears parser state, line values, sums and the count.
module ascii_imu_line_running_mean
    import aimu_pkg::*;
#(
    parameter int COUNT_BITS   = aimu_pkg::COUNT_BITS_DEF,
    parameter int NUM_CHANNELS = aimu_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_line_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [aimu_pkg::VAL_W-1:0]   o_mean_accel_x,
    output logic signed [aimu_pkg::VAL_W-1:0]   o_mean_accel_y,
    output logic signed [aimu_pkg::VAL_W-1:0]   o_mean_accel_z,
    output logic signed [aimu_pkg::VAL_W-1:0]   o_mean_gyro_x,
    output logic signed [aimu_pkg::VAL_W-1:0]   o_mean_gyro_y,
    output logic signed [aimu_pkg::VAL_W-1:0]   o_mean_gyro_z,
    output logic [aimu_pkg::LINES_W-1:0]        o_lines_seen,
    output logic                                o_count_full
);
    import aimu_pkg::*;

    localparam int CH_W  = $clog2(NUM_CHANNELS);
    localparam int IT_W  = $clog2(SUM_W + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [23:0]             r_prefix;
    logic [2:0]              r_tlen;
    logic [3:0]              r_target;
    logic [1:0]              r_phase;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic signed [VAL_W-1:0] r_vals [NUM_CHANNELS];
    logic [SUM_W-1:0]        r_sums [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]   r_count;
    logic                    r_sat;
    logic signed [VAL_W-1:0] r_means [NUM_CHANNELS];
    logic                    r_ovalid;

    // Serial divider state: magnitude of the dividend shifts through r_quo.
    logic [CH_W-1:0]         r_ch;
    logic [IT_W-1:0]         r_it;
    logic [SUM_W-1:0]        r_quo;
    logic [COUNT_BITS:0]     r_rem;
    logic                    r_qneg;

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);

    // Value commit for the pending field.
    logic signed [VAL_W-1:0] commit_v;
    always_comb begin
        if (r_neg)
            commit_v = (r_mag > MAG_W'(32768)) ? VAL_W'(-32768) : -VAL_W'(r_mag);
        else
            commit_v = (r_mag > MAG_W'(32767)) ? VAL_W'(32767) : VAL_W'(r_mag);
    end

    function automatic logic [CH_W-1:0] f_slot(input logic [3:0] t);
        logic [2:0] k;
        k = 3'(t - 4'd1);
        if (k < TMP_KEY) return CH_W'(k);
        return CH_W'(k - 3'd1);
    endfunction

    logic [3:0] key_hit;
    always_comb begin
        key_hit = '0;
        for (int k = 0; k < NUM_KEYS; k++)
            if (r_prefix == KEY_CODES[k]) key_hit = 4'(k + 1);
    end

    // A line-end word commits the pending value itself, whether it ends or continues a token.
    logic end_commit;
    always_comb begin
        end_commit = i_line_end && r_target != 4'd0 && r_target != 4'(TMP_KEY + 1) &&
                     (!f_is_sep(i_text_byte) || r_tlen != 3'd0);
    end

    // Digit step for the value parser.
    logic       is_dig;
    logic [1:0] ph_next;
    logic       feed_skip;
    logic       feed_sign;
    logic [MAG_W+4:0] mag_calc;
    always_comb begin
        is_dig    = i_text_byte >= 8'h30 && i_text_byte <= 8'h39;
        feed_skip = 1'b0;
        feed_sign = 1'b0;
        ph_next   = r_phase;
        unique case (r_phase)
            PH_SKIP: begin
                if (f_is_ws(i_text_byte)) feed_skip = 1'b1;
                else if (i_text_byte == 8'h2B || i_text_byte == 8'h2D) feed_sign = 1'b1;
                else ph_next = is_dig ? PH_DIGIT : PH_DONE;
            end
            PH_SIGN:  ph_next = is_dig ? PH_DIGIT : PH_DONE;
            PH_DIGIT: if (!is_dig) ph_next = PH_DONE;
            default:  ph_next = PH_DONE;
        endcase
        mag_calc = (MAG_W+5)'(r_mag) * (MAG_W+5)'(10) + (MAG_W+5)'(i_text_byte - 8'h30);
    end

    logic [COUNT_BITS:0] rem_sh;
    logic [COUNT_BITS:0] rem_sub;
    assign rem_sh  = {r_rem[COUNT_BITS-1:0], r_quo[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_count};

    logic [SUM_W-1:0] sum_sel;
    assign sum_sel = r_sums[r_ch];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && i_line_end) n_state = S_DIV;
            S_DIV:  if (r_it == IT_W'(SUM_W + 1) && r_ch == CH_W'(NUM_CHANNELS - 1))
                        n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prefix <= '0;
            r_tlen   <= '0;
            r_target <= '0;
            r_phase  <= PH_SKIP;
            r_mag    <= '0;
            r_neg    <= 1'b0;
            r_count  <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
            r_ch     <= '0;
            r_it     <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_vals[i] <= '0;
                r_sums[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (accept) begin
                logic [23:0]             t_prefix;
                logic [3:0]              t_target;
                logic [2:0]              t_tlen;
                logic [1:0]              t_phase;
                logic [MAG_W-1:0]        t_mag;
                logic                    t_neg;
                t_prefix = r_prefix;
                t_target = r_target;
                t_tlen   = r_tlen;
                t_phase  = r_phase;
                t_mag    = r_mag;
                t_neg    = r_neg;
                if (f_is_sep(i_text_byte)) begin
                    if (r_tlen != 3'd0) begin
                        if (r_target != 4'd0) begin
                            if (r_target != 4'(TMP_KEY + 1) && !i_line_end)
                                r_vals[f_slot(r_target)] <= commit_v;
                            t_target = '0;
                        end else if (r_tlen == 3'd3) begin
                            t_target = key_hit;
                        end
                    end
                    t_prefix = '0;
                    t_tlen = '0; t_phase = PH_SKIP; t_mag = '0; t_neg = 1'b0;
                end else begin
                    if (r_target != 4'd0) begin
                        if (!feed_skip) begin
                            if (feed_sign) begin
                                t_neg   = (i_text_byte == 8'h2D);
                                t_phase = PH_SIGN;
                            end else begin
                                t_phase = ph_next;
                                if (ph_next == PH_DIGIT)
                                    t_mag = (mag_calc > (MAG_W+5)'(MAG_MAX)) ? MAG_MAX
                                                                              : MAG_W'(mag_calc);
                            end
                        end
                    end else if (r_tlen < 3'd3) begin
                        t_prefix = {r_prefix[15:0], i_text_byte};
                    end
                    if (r_tlen < 3'd4) t_tlen = r_tlen + 3'd1;
                end
                if (i_line_end) begin
                    // Close the line: commit a pending value, then add into the sums unless the count is saturated.
                    if (end_commit) begin
                        logic signed [VAL_W-1:0] cv;
                        if (f_is_sep(i_text_byte))
                            cv = commit_v;
                        else if (t_neg)
                            cv = (t_mag > MAG_W'(32768)) ? VAL_W'(-32768) : -VAL_W'(t_mag);
                        else
                            cv = (t_mag > MAG_W'(32767)) ? VAL_W'(32767) : VAL_W'(t_mag);
                        r_vals[f_slot(r_target)] <= cv;
                        if (r_count != COUNT_MAX)
                            r_sums[f_slot(r_target)] <= r_sums[f_slot(r_target)]
                                + SUM_W'(cv);
                    end
                    if (r_count == COUNT_MAX) begin
                        r_sat <= 1'b1;
                    end else begin
                        for (int i = 0; i < NUM_CHANNELS; i++)
                            if (!(end_commit && f_slot(r_target) == CH_W'(i)))
                                r_sums[i] <= r_sums[i] + SUM_W'(r_vals[i]);
                        r_count <= r_count + 1'b1;
                    end
                    t_prefix = '0;
                    t_target = '0; t_tlen = '0; t_phase = PH_SKIP; t_mag = '0; t_neg = 1'b0;
                    r_ch <= '0;
                    r_it <= '0;
                end
                r_prefix <= t_prefix;
                r_target <= t_target;
                r_tlen   <= t_tlen;
                r_phase  <= t_phase;
                r_mag    <= t_mag;
                r_neg    <= t_neg;
            end
            if (r_state == S_DIV) begin
                if (r_it == '0) begin
                    // Load the dividend magnitude and its sign.
                    r_qneg <= sum_sel[SUM_W-1];
                    r_quo  <= sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
                    r_rem  <= '0;
                    r_it   <= r_it + 1'b1;
                end else if (r_it <= IT_W'(SUM_W)) begin
                    if (!rem_sub[COUNT_BITS]) begin
                        r_rem <= rem_sub;
                        r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                    end
                    r_it <= r_it + 1'b1;
                end else begin
                    r_means[r_ch] <= r_qneg ? -VAL_W'(r_quo) : VAL_W'(r_quo);
                    r_it <= '0;
                    if (r_ch != CH_W'(NUM_CHANNELS - 1)) r_ch <= r_ch + 1'b1;
                end
            end
            if (r_state == S_OUT) r_ovalid <= 1'b1;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_mean_accel_x = r_means[0];
    assign o_mean_accel_y = r_means[1];
    assign o_mean_accel_z = r_means[2];
    assign o_mean_gyro_x  = r_means[3];
    assign o_mean_gyro_y  = r_means[4];
    assign o_mean_gyro_z  = r_means[5];
    assign o_lines_seen   = LINES_W'(r_count);
    assign o_count_full   = r_sat;
endmodule
